@@ design/shvd_pkg.sv @@
`default_nettype none
package shvd_pkg;

	localparam int MAX_DEGREE = 8;
	localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int DEG_W = 4;
	// Small integer factors such as 2l-1 and l+m-1 stay below 2^(DEG_W+1).
	localparam int K_W = DEG_W + 1;

	// Divider: dividend width, quotient bits per cycle and cycle count.
	localparam int DIV_W = 76;
	localparam int DIV_BPC = 4;
	localparam int DIV_STEPS = DIV_W / DIV_BPC;
	localparam int DEN_W = 33;
	localparam int SQRT_STEPS = 32;
	localparam int STEP_W = 6;

	localparam int PADDR_W = 3;
	localparam logic REG_DEGREE_MAX = 1'b0;

	localparam logic ACT_POINT = 1'b1;

	localparam logic signed [63:0] Q_ONE = 64'sh0000_0100_0000_0000;
	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic {
		DS_DIV,
		DS_SQRT
	} ds_mode_t;

	typedef struct packed {
		logic action;
		logic [6:0] coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic saturated;
	} out_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic signed [63:0] q40;
		logic [63:0] raw;
	} mul_res_t;

	typedef struct packed {
		logic start;
		ds_mode_t mode;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quot;
		logic [31:0] root;
	} div_res_t;

	typedef struct packed {
		logic sat;
		logic signed [63:0] val;
	} sval_t;

	function automatic sval_t f_sadd(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		sval_t r;
		s = {a[63], a} + {b[63], b};
		r.sat = (s[64] != s[63]);
		r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
		return r;
	endfunction

	function automatic sval_t f_ssub(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		sval_t r;
		s = {a[63], a} - {b[63], b};
		r.sat = (s[64] != s[63]);
		r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
		return r;
	endfunction

	function automatic sval_t f_sneg(logic signed [63:0] a);
		sval_t r;
		r.sat = (a == Q_MIN);
		r.val = r.sat ? Q_MAX : -a;
		return r;
	endfunction

	function automatic sval_t f_smuli(logic signed [63:0] a, logic [K_W-1:0] k);
		logic signed [63+K_W+1:0] p;
		sval_t r;
		p = a * $signed({1'b0, k});
		r.sat = (p[63+K_W+1:63] != {(K_W+2){p[63]}});
		r.val = r.sat ? (p[63+K_W+1] ? Q_MIN : Q_MAX) : p[63:0];
		return r;
	endfunction

	function automatic sval_t f_clamp32(logic signed [63:0] a);
		sval_t r;
		r.sat = 1'b0;
		r.val = a;
		if (a > 64'sh0000_0000_7FFF_FFFF) begin
			r.sat = 1'b1;
			r.val = 64'sh0000_0000_7FFF_FFFF;
		end else if (a < -64'sh0000_0000_8000_0000) begin
			r.sat = 1'b1;
			r.val = -64'sh0000_0000_8000_0000;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] f_ratio(logic [DIV_W-1:0] quot, logic negative);
		logic signed [63:0] q;
		q = (quot > DIV_W'(Q_ONE)) ? Q_ONE : $signed(quot[63:0]);
		return negative ? -q : q;
	endfunction

	function automatic logic [ADDR_W-1:0] f_slot(logic [DEG_W-1:0] l, logic [DEG_W-1:0] m,
			logic negative);
		logic [9:0] s;
		s = 10'(l) * 10'(l) + 10'(l);
		s = negative ? s - 10'(m) : s + 10'(m);
		return ADDR_W'(s);
	endfunction

endpackage
`default_nettype wire

@@ design/shvd_mul.sv @@
`default_nettype none
module shvd_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire shvd_pkg::mul_req_t req,
	output shvd_pkg::mul_res_t res
);
	import shvd_pkg::*;

	logic [63:0] ua_q;
	logic [63:0] ub_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic [2:0] step_q;
	logic busy_q;
	logic done_q;
	logic sat_q;
	logic signed [63:0] q40_q;

	logic [31:0] opa;
	logic [31:0] opb;
	logic [63:0] pp;
	logic [6:0] sh;
	logic [127:0] pp_sh;
	logic [127:0] prod;
	logic [127:0] rnd;
	logic fits;

	// Four 32x32 partial products, one per cycle, then sign, rounding and range check.
	always_comb begin
		opa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
		opb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = opa * opb;
		sh = (step_q == 3'd0) ? 7'd0 : ((step_q == 3'd3) ? 7'd64 : 7'd32);
		pp_sh = {64'b0, pp} << sh;
		prod = neg_q ? (~acc_q + 128'd1) : acc_q;
		rnd = prod + (128'd1 << 39);
		fits = (rnd[127:103] == {25{rnd[127]}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ua_q <= req.a[63] ? (~req.a + 64'd1) : req.a;
				ub_q <= req.b[63] ? (~req.b + 64'd1) : req.b;
				neg_q <= req.a[63] != req.b[63];
				acc_q <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q != 3'd4) begin
					acc_q <= acc_q + pp_sh;
					step_q <= step_q + 3'd1;
				end else begin
					sat_q <= !fits;
					q40_q <= fits ? $signed(rnd[103:40]) : (rnd[127] ? Q_MIN : Q_MAX);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.sat = sat_q;
	assign res.q40 = q40_q;
	assign res.raw = acc_q[63:0];

endmodule
`default_nettype wire

@@ design/shvd_divsqrt.sv @@
`default_nettype none
module shvd_divsqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire shvd_pkg::div_req_t req,
	output shvd_pkg::div_res_t res
);
	import shvd_pkg::*;

	logic busy_q;
	logic done_q;
	ds_mode_t mode_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W:0] rem_q;
	logic [DIV_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [63:0] v_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;

	logic [DEN_W:0] rem_n;
	logic [DIV_W-1:0] quot_n;
	logic [DEN_W:0] shv;
	logic [63:0] trial;
	logic last;

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		rem_n = rem_q;
		quot_n = quot_q;
		for (int i = 0; i < DIV_BPC; i++) begin
			shv = {rem_n[DEN_W-1:0], quot_n[DIV_W-1]};
			quot_n = {quot_n[DIV_W-2:0], 1'b0};
			if (shv >= {1'b0, den_q}) begin
				rem_n = shv - {1'b0, den_q};
				quot_n[0] = 1'b1;
			end else begin
				rem_n = shv;
			end
		end
		trial = root_q + bit_q;
		last = (mode_q == DS_SQRT) ? (cnt_q == STEP_W'(SQRT_STEPS - 1))
			: (cnt_q == STEP_W'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				mode_q <= req.mode;
				cnt_q <= '0;
				busy_q <= 1'b1;
				rem_q <= '0;
				quot_q <= req.num;
				den_q <= req.den;
				v_q <= req.num[63:0];
				root_q <= '0;
				bit_q <= 64'd1 << 62;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (mode_q == DS_SQRT) begin
					if (v_q >= trial) begin
						v_q <= v_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q <= rem_n;
					quot_q <= quot_n;
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.root = root_q[31:0];

endmodule
`default_nettype wire

@@ design/spherical_harmonic_vertex_displacer_core.sv @@
// Spherical-harmonic vertex displacer.
// Item channel (item_valid/item_ready/item): a transaction with action 0 stores one
// coefficient in slot coef_index (slots past the table are dropped) and gives no result;
// action 1 displaces one point and gives one transaction on the result channel.
// Register degree_max (APB, byte address 0) sets the highest degree; it must be written
// only while the block is idle, which the block itself does not enforce.
// Every product runs through one shared 64x64 multiplier built from four 32x32 partial
// products, and each recurrence step needs a divide in the shared divide/square-root
// unit, which also takes the two square roots and up to four ratios per point.
// A zero point skips the computation and goes straight to S_FIN with a zero result;
// item_ready is high only while idle.
// The result register holds a finished point until it is taken; a stalled receiver
// holds the sequencer in its last state only once a second point is finished.
// Reset clears the sequencer, the result valid and degree_max; the coefficient
// table is not cleared and must be written before it is used.
`default_nettype none
module spherical_harmonic_vertex_displacer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire shvd_pkg::in_t item,
	output logic result_valid,
	input wire logic result_ready,
	output shvd_pkg::out_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [shvd_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import shvd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_NORM, S_SQX, S_SQY, S_SQZ, S_RHO, S_R, S_CT, S_ST, S_CP, S_SP, S_SPD,
		S_INIT, S_TERM, S_TRA, S_TRB, S_TNEG, S_THS, S_TSUM, S_TACC, S_PB1, S_PB2,
		S_REC1, S_REC2, S_REC3, S_RDIV, S_REC4, S_PMM, S_PMM2, S_ROT1, S_ROT2, S_ROT3,
		S_ROT4, S_ROT5, S_OX, S_OY, S_OZ, S_OEND, S_FIN, S_WAIT
	} state_t;

	state_t state_q;
	state_t ret_q;
	logic [DEG_W-1:0] deg_q;
	logic [DEG_W-1:0] lmax_q;
	logic [DEG_W-1:0] m_q;
	logic [DEG_W-1:0] l_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic [31:0] ax_q;
	logic [31:0] ay_q;
	logic [31:0] az_q;
	logic [63:0] rho2_q;
	logic [63:0] rr2_q;
	logic [31:0] rho_q;
	logic [31:0] r_q;
	logic signed [63:0] ct_q, st_q, cp_q, sp_q;
	logic signed [63:0] sum_q, pmm_q, cm_q, sm_q;
	logic signed [63:0] pam_q, pbm_q, pv_q, h_q, ta_q, tb_q;
	logic sat_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	out_t res_q;
	logic out_valid_q;
	mul_req_t mul_req_q;
	div_req_t div_req_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [31:0] rdata_q;
	logic [31:0] coef_mem [STORE_DEPTH];

	mul_res_t mul_res;
	div_res_t div_res;

	logic item_acc;
	logic wr_en;
	logic [31:0] mx;
	logic signed [63:0] coef_w;
	logic signed [63:0] mq;
	logic [63:0] ta_mag;
	logic [63:0] plm_mag;
	logic cfg_wr;

	shvd_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req_q),
		.res(mul_res)
	);

	shvd_divsqrt u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req_q),
		.res(div_res)
	);

	assign item_ready = (state_q == S_IDLE);
	assign item_acc = item_valid && item_ready;
	assign wr_en = item_acc && (item.action != ACT_POINT)
		&& (int'(item.coef_index) < STORE_DEPTH);
	assign result_valid = out_valid_q;
	assign result = res_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEGREE_MAX);
	assign prdata = (paddr[2] == REG_DEGREE_MAX) ? 32'(deg_q) : 32'd0;

	always_comb begin
		mx = (ax_q > ay_q) ? ax_q : ay_q;
		if (az_q > mx) begin
			mx = az_q;
		end
		// A stored coefficient is Q8.24; internal values are Q24.40.
		coef_w = {{16{rdata_q[31]}}, rdata_q, 16'b0};
		mq = mul_res.q40;
		ta_mag = ta_q[63] ? (~ta_q + 64'd1) : ta_q;
		plm_mag = div_res.quot[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= '0;
		end else if (cfg_wr) begin
			deg_q <= pwdata[DEG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[ADDR_W'(item.coef_index)] <= item.coef_value;
		end
		rdata_q <= coef_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc && (item.action == ACT_POINT)) begin
						x_q <= item.pos_x;
						y_q <= item.pos_y;
						z_q <= item.pos_z;
						ax_q <= item.pos_x[31] ? (~item.pos_x + 32'd1) : item.pos_x;
						ay_q <= item.pos_y[31] ? (~item.pos_y + 32'd1) : item.pos_y;
						az_q <= item.pos_z[31] ? (~item.pos_z + 32'd1) : item.pos_z;
						sat_q <= 1'b0;
						if ((item.pos_x == '0) && (item.pos_y == '0) && (item.pos_z == '0)) begin
							ox_q <= '0;
							oy_q <= '0;
							oz_q <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					// Scale all magnitudes together until the largest passes 2^30.
					if (mx <= 32'h4000_0000) begin
						ax_q <= ax_q << 1;
						ay_q <= ay_q << 1;
						az_q <= az_q << 1;
					end else begin
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					mul_req_q <= '{start: 1'b1, a: $signed({32'b0, ax_q}),
						b: $signed({32'b0, ax_q})};
					ret_q <= S_SQY;
					state_q <= S_WAIT;
				end
				S_SQY: begin
					rho2_q <= mul_res.raw;
					mul_req_q <= '{start: 1'b1, a: $signed({32'b0, ay_q}),
						b: $signed({32'b0, ay_q})};
					ret_q <= S_SQZ;
					state_q <= S_WAIT;
				end
				S_SQZ: begin
					rho2_q <= rho2_q + mul_res.raw;
					mul_req_q <= '{start: 1'b1, a: $signed({32'b0, az_q}),
						b: $signed({32'b0, az_q})};
					ret_q <= S_RHO;
					state_q <= S_WAIT;
				end
				S_RHO: begin
					rr2_q <= rho2_q + mul_res.raw;
					div_req_q <= '{start: 1'b1, mode: DS_SQRT, num: DIV_W'(rho2_q), den: '0};
					ret_q <= S_R;
					state_q <= S_WAIT;
				end
				S_R: begin
					rho_q <= div_res.root;
					div_req_q <= '{start: 1'b1, mode: DS_SQRT, num: DIV_W'(rr2_q), den: '0};
					ret_q <= S_CT;
					state_q <= S_WAIT;
				end
				S_CT: begin
					r_q <= div_res.root;
					div_req_q <= '{start: 1'b1, mode: DS_DIV, num: DIV_W'({az_q, 40'b0}),
						den: DEN_W'(div_res.root)};
					ret_q <= S_ST;
					state_q <= S_WAIT;
				end
				S_ST: begin
					ct_q <= f_ratio(div_res.quot, z_q[31]);
					div_req_q <= '{start: 1'b1, mode: DS_DIV, num: DIV_W'({rho_q, 40'b0}),
						den: DEN_W'(r_q)};
					ret_q <= S_CP;
					state_q <= S_WAIT;
				end
				S_CP: begin
					st_q <= f_ratio(div_res.quot, 1'b0);
					if (rho_q == '0) begin
						// On the z axis the azimuth is taken as zero.
						cp_q <= Q_ONE;
						sp_q <= '0;
						state_q <= S_INIT;
					end else begin
						div_req_q <= '{start: 1'b1, mode: DS_DIV, num: DIV_W'({ax_q, 40'b0}),
							den: DEN_W'(rho_q)};
						ret_q <= S_SP;
						state_q <= S_WAIT;
					end
				end
				S_SP: begin
					cp_q <= f_ratio(div_res.quot, x_q[31]);
					div_req_q <= '{start: 1'b1, mode: DS_DIV, num: DIV_W'({ay_q, 40'b0}),
						den: DEN_W'(rho_q)};
					ret_q <= S_SPD;
					state_q <= S_WAIT;
				end
				S_SPD: begin
					sp_q <= f_ratio(div_res.quot, y_q[31]);
					state_q <= S_INIT;
				end
				S_INIT: begin
					sum_q <= Q_ONE;
					pmm_q <= Q_ONE;
					pv_q <= Q_ONE;
					cm_q <= Q_ONE;
					sm_q <= '0;
					m_q <= '0;
					l_q <= '0;
					lmax_q <= (deg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q;
					state_q <= S_TERM;
				end
				S_TERM: begin
					rd_addr_q <= f_slot(l_q, m_q, 1'b0);
					state_q <= S_TRA;
				end
				S_TRA: begin
					rd_addr_q <= f_slot(l_q, m_q, 1'b1);
					state_q <= S_TRB;
				end
				S_TRB: begin
					if (m_q == '0) begin
						h_q <= coef_w;
						state_q <= S_TSUM;
					end else begin
						mul_req_q <= '{start: 1'b1, a: coef_w, b: cm_q};
						ret_q <= S_TNEG;
						state_q <= S_WAIT;
					end
				end
				S_TNEG: begin
					// The read data now holds the coefficient of the negative order.
					ta_q <= mq;
					sat_q <= sat_q | mul_res.sat;
					mul_req_q <= '{start: 1'b1, a: coef_w, b: sm_q};
					ret_q <= S_THS;
					state_q <= S_WAIT;
				end
				S_THS: begin
					h_q <= f_sadd(ta_q, mq).val;
					sat_q <= sat_q | mul_res.sat | f_sadd(ta_q, mq).sat;
					state_q <= S_TSUM;
				end
				S_TSUM: begin
					mul_req_q <= '{start: 1'b1, a: pv_q, b: h_q};
					ret_q <= S_TACC;
					state_q <= S_WAIT;
				end
				S_TACC: begin
					sum_q <= f_sadd(sum_q, mq).val;
					sat_q <= sat_q | mul_res.sat | f_sadd(sum_q, mq).sat;
					if (l_q == m_q) begin
						state_q <= (m_q < lmax_q) ? S_PB1 : S_PMM;
					end else begin
						state_q <= (l_q < lmax_q) ? S_REC1 : S_PMM;
					end
				end
				S_PB1: begin
					pam_q <= pmm_q;
					mul_req_q <= '{start: 1'b1, a: ct_q, b: pmm_q};
					ret_q <= S_PB2;
					state_q <= S_WAIT;
				end
				S_PB2: begin
					pbm_q <= f_smuli(mq, {m_q, 1'b1}).val;
					pv_q <= f_smuli(mq, {m_q, 1'b1}).val;
					sat_q <= sat_q | mul_res.sat | f_smuli(mq, {m_q, 1'b1}).sat;
					l_q <= m_q + DEG_W'(1);
					state_q <= S_TERM;
				end
				S_REC1: begin
					mul_req_q <= '{start: 1'b1, a: ct_q, b: pbm_q};
					l_q <= l_q + DEG_W'(1);
					ret_q <= S_REC2;
					state_q <= S_WAIT;
				end
				S_REC2: begin
					ta_q <= f_smuli(mq, {l_q, 1'b0} - K_W'(1)).val;
					sat_q <= sat_q | mul_res.sat | f_smuli(mq, {l_q, 1'b0} - K_W'(1)).sat;
					state_q <= S_REC3;
				end
				S_REC3: begin
					ta_q <= f_ssub(ta_q, f_smuli(pam_q, K_W'(l_q) + K_W'(m_q) - K_W'(1)).val).val;
					sat_q <= sat_q | f_smuli(pam_q, K_W'(l_q) + K_W'(m_q) - K_W'(1)).sat
						| f_ssub(ta_q,
							f_smuli(pam_q, K_W'(l_q) + K_W'(m_q) - K_W'(1)).val).sat;
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					div_req_q <= '{start: 1'b1, mode: DS_DIV, num: DIV_W'(ta_mag),
						den: DEN_W'(l_q - m_q)};
					ret_q <= S_REC4;
					state_q <= S_WAIT;
				end
				S_REC4: begin
					// Quotient truncates toward zero: divide the magnitude, then restore sign.
					pam_q <= pbm_q;
					pbm_q <= ta_q[63] ? -$signed(plm_mag) : $signed(plm_mag);
					pv_q <= ta_q[63] ? -$signed(plm_mag) : $signed(plm_mag);
					state_q <= S_TERM;
				end
				S_PMM: begin
					mul_req_q <= '{start: 1'b1, a: pmm_q, b: st_q};
					ret_q <= S_PMM2;
					state_q <= S_WAIT;
				end
				S_PMM2: begin
					pmm_q <= f_sneg(f_smuli(mq, {m_q, 1'b1}).val).val;
					sat_q <= sat_q | mul_res.sat | f_smuli(mq, {m_q, 1'b1}).sat
						| f_sneg(f_smuli(mq, {m_q, 1'b1}).val).sat;
					state_q <= S_ROT1;
				end
				S_ROT1: begin
					mul_req_q <= '{start: 1'b1, a: cm_q, b: cp_q};
					ret_q <= S_ROT2;
					state_q <= S_WAIT;
				end
				S_ROT2: begin
					ta_q <= mq;
					sat_q <= sat_q | mul_res.sat;
					mul_req_q <= '{start: 1'b1, a: sm_q, b: sp_q};
					ret_q <= S_ROT3;
					state_q <= S_WAIT;
				end
				S_ROT3: begin
					ta_q <= f_ssub(ta_q, mq).val;
					sat_q <= sat_q | mul_res.sat | f_ssub(ta_q, mq).sat;
					mul_req_q <= '{start: 1'b1, a: sm_q, b: cp_q};
					ret_q <= S_ROT4;
					state_q <= S_WAIT;
				end
				S_ROT4: begin
					tb_q <= mq;
					sat_q <= sat_q | mul_res.sat;
					mul_req_q <= '{start: 1'b1, a: cm_q, b: sp_q};
					ret_q <= S_ROT5;
					state_q <= S_WAIT;
				end
				S_ROT5: begin
					cm_q <= ta_q;
					sm_q <= f_sadd(tb_q, mq).val;
					sat_q <= sat_q | mul_res.sat | f_sadd(tb_q, mq).sat;
					if (m_q == lmax_q) begin
						state_q <= S_OX;
					end else begin
						m_q <= m_q + DEG_W'(1);
						l_q <= m_q + DEG_W'(1);
						pv_q <= pmm_q;
						state_q <= S_TERM;
					end
				end
				S_OX: begin
					mul_req_q <= '{start: 1'b1, a: 64'(x_q), b: sum_q};
					ret_q <= S_OY;
					state_q <= S_WAIT;
				end
				S_OY: begin
					ox_q <= f_clamp32(mq).val[31:0];
					sat_q <= sat_q | mul_res.sat | f_clamp32(mq).sat;
					mul_req_q <= '{start: 1'b1, a: 64'(y_q), b: sum_q};
					ret_q <= S_OZ;
					state_q <= S_WAIT;
				end
				S_OZ: begin
					oy_q <= f_clamp32(mq).val[31:0];
					sat_q <= sat_q | mul_res.sat | f_clamp32(mq).sat;
					mul_req_q <= '{start: 1'b1, a: 64'(z_q), b: sum_q};
					ret_q <= S_OEND;
					state_q <= S_WAIT;
				end
				S_OEND: begin
					oz_q <= f_clamp32(mq).val[31:0];
					sat_q <= sat_q | mul_res.sat | f_clamp32(mq).sat;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result_ready) begin
						res_q <= '{out_x: ox_q, out_y: oy_q, out_z: oz_q, saturated: sat_q};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (mul_res.done || div_res.done) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
